// ===== rtl/pmf_pkg.sv =====
// Shared widths, types and codes of the polyline moving-frame block.
package pmf_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int COL_W       = 32;
    localparam int FRAC_W      = 16;
    localparam int Q_W         = FRAC_W + 1;
    localparam int SC_W        = 24;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int MAG_W       = (2 * SC_W + 1 > DIFF_W) ? 2 * SC_W + 1 : DIFF_W;
    localparam int PROD_W      = 2 * SC_W;
    localparam int ACC_W       = 2 * SC_W + 3;
    localparam int SQ_W        = 2 * SC_W + 2;
    localparam int LEN_W       = SC_W + 1;
    localparam int NUM_W       = SC_W + FRAC_W + 1;
    localparam int NORM_STEP   = 8;

    typedef logic [MAG_W-1:0] t_mag;
    typedef logic [SC_W-1:0]  t_scaled;

    typedef enum logic [1:0] {
        COL_B   = 2'd0,
        COL_N   = 2'd1,
        COL_T   = 2'd2,
        COL_ORG = 2'd3
    } t_col;

endpackage

// ===== rtl/pmf_norm.sv =====
// Block-scaling unit: shifts a three-component magnitude vector into [2^23, 2^24).
module pmf_norm
    import pmf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_mag    i_mag [3],
    output logic    o_done,
    output t_scaled o_mag [3]
);

    logic r_busy;
    t_mag r_mag [3];
    t_mag orv;
    logic big, over, tiny;

    // The OR of the magnitudes has the same leading bit as their maximum.
    assign orv  = r_mag[0] | r_mag[1] | r_mag[2];
    assign big  = |orv[MAG_W-1:SC_W+NORM_STEP-1];
    assign over = |orv[MAG_W-1:SC_W];
    assign tiny = ~|orv[SC_W-1:SC_W-NORM_STEP-1];

    assign o_done = r_busy && ((orv == '0) || (!over && orv[SC_W-1]));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_mag[i] = r_mag[i][SC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_mag;
        end else if (r_busy && !o_done) begin
            for (int i = 0; i < 3; i++) begin
                priority if (big) begin
                    r_mag[i] <= r_mag[i] >> NORM_STEP;
                end else if (over) begin
                    r_mag[i] <= r_mag[i] >> 1;
                end else if (tiny) begin
                    r_mag[i] <= r_mag[i] << NORM_STEP;
                end else begin
                    r_mag[i] <= r_mag[i] << 1;
                end
            end
        end
    end

endmodule

// ===== rtl/pmf_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module pmf_sqrt
    import pmf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SQ_W-1:0]  i_x,
    output logic             o_done,
    output logic [LEN_W-1:0] o_root
);

    logic            r_busy;
    logic            r_done;
    logic [SQ_W-1:0] r_x;
    logic [SQ_W-1:0] r_res;
    logic [SQ_W-1:0] r_bit;
    logic [SQ_W-1:0] trial;

    assign trial  = r_res + r_bit;
    assign o_done = r_done;
    assign o_root = r_res[LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_bit[0];
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_res <= '0;
            r_bit <= SQ_W'(1) << (SQ_W - 2);
        end else if (r_busy) begin
            if (r_x >= trial) begin
                r_x   <= r_x - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

endmodule

// ===== rtl/pmf_div.sv =====
// Restoring divider for the unit-vector quotients, one quotient bit per cycle.
module pmf_div
    import pmf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [LEN_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quo
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [LEN_W-1:0] r_rem;
    logic [LEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_lo;
    logic [LEN_W:0]   trial;
    logic             fits;

    // The quotient fits in Q_W bits, so the upper numerator bits start below the divisor.
    assign trial  = {r_rem, r_lo[Q_W-1]};
    assign fits   = trial >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quo  = r_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= LEN_W'(i_num[NUM_W-1:Q_W]);
            r_lo  <= i_num[Q_W-1:0];
            r_den <= i_den;
            r_cnt <= CNT_W'(Q_W);
        end else if (r_busy) begin
            r_rem <= fits ? LEN_W'(trial - {1'b0, r_den}) : trial[LEN_W-1:0];
            r_lo  <= {r_lo[Q_W-2:0], fits};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

endmodule

// ===== rtl/polyline_moving_frame.sv =====
// Moving frame along a polyline: sequencer with one shared multiplier and iterative units.
// A point that only fills the history is taken while the sequencer stays idle. A point that
// completes a window runs the two unit-vector passes (25-step square root and three 17-step
// divisions each) and the block scaling before its first column. Columns then leave one per
// cycle unless stalled. Synchronous active-low reset clears the point history, the point
// count and the output valid.
module polyline_moving_frame
    import pmf_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_z,
    input  logic                          i_final_point,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COL_W-1:0]       o_col_x,
    output logic signed [COL_W-1:0]       o_col_y,
    output logic signed [COL_W-1:0]       o_col_z,
    output logic [1:0]                    o_column_index,
    output logic                          o_degenerate,
    output logic                          o_end_of_run
);

    typedef enum logic [3:0] {
        S_IDLE, S_LD_D1, S_WT_D1, S_LD_D2, S_WT_D2, S_MUL, S_ACC, S_SQRT_GO,
        S_SQRT_WT, S_DIV_GO, S_DIV_WT, S_LD_N, S_WT_N, S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_AC, OP_SQ, OP_TN
    } t_op;

    function automatic logic [COL_W-1:0] q_col(input logic [Q_W-1:0] m, input logic s);
        logic [COL_W-1:0] v;
        v = COL_W'(m);
        return s ? -v : v;
    endfunction

    function automatic logic [COL_W-1:0] p_col(input logic signed [COORD_WIDTH-1:0] p);
        logic signed [COL_W+COORD_WIDTH-1:0] w;
        w = (COL_W + COORD_WIDTH)'(p);
        return w[COL_W-1:0];
    endfunction

    t_state r_state;
    t_op    r_op;
    logic   r_phase_n;
    logic [2:0] r_idx;
    logic [1:0] r_seen;
    logic       r_fin;

    logic signed [COORD_WIDTH-1:0] r_hist0 [3];
    logic signed [COORD_WIDTH-1:0] r_hist1 [3];
    logic signed [COORD_WIDTH-1:0] r_cur [3];

    t_scaled r_a_mag [3];
    logic    r_a_sgn [3];
    t_scaled r_c_mag [3];
    logic    r_c_sgn [3];
    t_scaled r_u_mag [3];
    logic    r_u_sgn [3];
    t_mag    r_cr_mag [3];
    logic    r_cr_sgn [3];
    logic [Q_W-1:0] r_t_mag [3];
    logic           r_t_sgn [3];
    logic [Q_W-1:0] r_n_mag [3];
    logic           r_n_sgn [3];
    logic [COL_W-1:0] r_b [3];
    logic             r_deg;

    logic [PROD_W-1:0]       r_prod;
    logic                    r_pneg;
    logic signed [ACC_W-1:0] r_acc;
    logic [LEN_W-1:0]        r_len;

    t_col       r_col;
    logic [1:0] r_frm;
    logic [1:0] r_last_frm;

    logic             r_out_valid;
    logic [COL_W-1:0] r_out_x;
    logic [COL_W-1:0] r_out_y;
    logic [COL_W-1:0] r_out_z;
    t_col             r_out_idx;
    logic             r_out_deg;
    logic             r_out_eor;

    logic signed [DIFF_W-1:0] d1 [3];
    logic signed [DIFF_W-1:0] d2 [3];
    logic    nrm_start;
    t_mag    nrm_in [3];
    logic    nrm_done;
    t_scaled nrm_out [3];
    logic    deg_now;
    t_mag    te_mag [3];
    logic    te_sgn [3];
    logic [1:0] ai, ci, kk;
    t_scaled opa, opb;
    logic    neg;
    logic [ACC_W-1:0]        term_u;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W-1:0] sum;
    logic [ACC_W-1:0]        sum_mag;
    logic [ACC_W-1:0]        rnd;
    logic [COL_W-1:0]        b_val;
    logic             sq_done;
    logic [LEN_W-1:0] sq_root;
    logic [NUM_W-1:0] div_num;
    logic             div_done;
    logic [Q_W-1:0]   div_quo;
    logic [Q_W-1:0]   q_val;
    logic             emit_last;
    logic [COL_W-1:0] col_x, col_y, col_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d1[i] = DIFF_W'(r_hist1[i]) - DIFF_W'(r_hist0[i]);
            d2[i] = DIFF_W'(r_cur[i]) - DIFF_W'(r_hist0[i]);
        end
    end

    // Fallback normal: cross t with the unit axis of t's smallest magnitude.
    assign deg_now = (r_cr_mag[0] | r_cr_mag[1] | r_cr_mag[2]) == '0;

    always_comb begin
        logic use_x, use_z;
        use_x = r_t_mag[0] < r_t_mag[1];
        use_z = use_x ? (r_t_mag[2] < r_t_mag[0]) : (r_t_mag[2] < r_t_mag[1]);
        priority if (use_z) begin
            te_mag[0] = MAG_W'(r_t_mag[1]); te_sgn[0] = r_t_sgn[1];
            te_mag[1] = MAG_W'(r_t_mag[0]); te_sgn[1] = ~r_t_sgn[0];
            te_mag[2] = '0;                 te_sgn[2] = 1'b0;
        end else if (use_x) begin
            te_mag[0] = '0;                 te_sgn[0] = 1'b0;
            te_mag[1] = MAG_W'(r_t_mag[2]); te_sgn[1] = r_t_sgn[2];
            te_mag[2] = MAG_W'(r_t_mag[1]); te_sgn[2] = ~r_t_sgn[1];
        end else begin
            te_mag[0] = MAG_W'(r_t_mag[2]); te_sgn[0] = ~r_t_sgn[2];
            te_mag[1] = '0;                 te_sgn[1] = 1'b0;
            te_mag[2] = MAG_W'(r_t_mag[0]); te_sgn[2] = r_t_sgn[0];
        end
    end

    always_comb begin
        nrm_start = 1'b0;
        for (int i = 0; i < 3; i++) begin
            nrm_in[i] = '0;
        end
        unique case (r_state)
            S_LD_D1: begin
                nrm_start = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    nrm_in[i] = MAG_W'(d1[i] < 0 ? -d1[i] : d1[i]);
                end
            end
            S_LD_D2: begin
                nrm_start = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    nrm_in[i] = MAG_W'(d2[i] < 0 ? -d2[i] : d2[i]);
                end
            end
            S_LD_N: begin
                nrm_start = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    nrm_in[i] = deg_now ? te_mag[i] : r_cr_mag[i];
                end
            end
            default: ;
        endcase
    end

    // Cross product term order: each component is a first product minus a second one.
    always_comb begin
        ai = 2'd0;
        ci = 2'd0;
        unique case (r_idx)
            3'd0: begin ai = 2'd1; ci = 2'd2; end
            3'd1: begin ai = 2'd2; ci = 2'd1; end
            3'd2: begin ai = 2'd2; ci = 2'd0; end
            3'd3: begin ai = 2'd0; ci = 2'd2; end
            3'd4: begin ai = 2'd0; ci = 2'd1; end
            3'd5: begin ai = 2'd1; ci = 2'd0; end
            default: ;
        endcase
        kk = r_idx[2:1];
    end

    always_comb begin
        unique case (r_op)
            OP_AC: begin
                opa = r_a_mag[ai];
                opb = r_c_mag[ci];
                neg = r_a_sgn[ai] ^ r_c_sgn[ci] ^ r_idx[0];
            end
            OP_TN: begin
                opa = SC_W'(r_t_mag[ai]);
                opb = SC_W'(r_n_mag[ci]);
                neg = r_t_sgn[ai] ^ r_n_sgn[ci] ^ r_idx[0];
            end
            default: begin
                opa = r_u_mag[r_idx[1:0]];
                opb = r_u_mag[r_idx[1:0]];
                neg = 1'b0;
            end
        endcase
    end

    always_comb begin
        term_u   = ACC_W'(r_prod);
        term     = r_pneg ? -signed'(term_u) : signed'(term_u);
        acc_base = ((r_op == OP_SQ) ? (r_idx == 3'd0) : !r_idx[0]) ? '0 : r_acc;
        sum      = acc_base + term;
        sum_mag  = sum < 0 ? ACC_W'(-sum) : ACC_W'(sum);
        rnd      = (sum_mag + ACC_W'(1 << (FRAC_W - 1))) >> FRAC_W;
        b_val    = sum < 0 ? -COL_W'(rnd) : COL_W'(rnd);
    end

    assign div_num = NUM_W'({r_u_mag[r_idx[1:0]], {FRAC_W{1'b0}}}) + NUM_W'(r_len >> 1);
    assign q_val   = (r_len == '0) ? '0 : div_quo;

    always_comb begin
        unique case (r_col)
            COL_B: begin
                col_x = r_b[0];
                col_y = r_b[1];
                col_z = r_b[2];
            end
            COL_N: begin
                col_x = q_col(r_n_mag[0], r_n_sgn[0]);
                col_y = q_col(r_n_mag[1], r_n_sgn[1]);
                col_z = q_col(r_n_mag[2], r_n_sgn[2]);
            end
            COL_T: begin
                col_x = q_col(r_t_mag[0], r_t_sgn[0]);
                col_y = q_col(r_t_mag[1], r_t_sgn[1]);
                col_z = q_col(r_t_mag[2], r_t_sgn[2]);
            end
            default: begin
                unique case (r_frm)
                    2'd0: begin
                        col_x = p_col(r_hist0[0]);
                        col_y = p_col(r_hist0[1]);
                        col_z = p_col(r_hist0[2]);
                    end
                    2'd1: begin
                        col_x = p_col(r_hist1[0]);
                        col_y = p_col(r_hist1[1]);
                        col_z = p_col(r_hist1[2]);
                    end
                    default: begin
                        col_x = p_col(r_cur[0]);
                        col_y = p_col(r_cur[1]);
                        col_z = p_col(r_cur[2]);
                    end
                endcase
            end
        endcase
    end

    assign emit_last = (r_col == COL_ORG) && (r_frm == r_last_frm);

    pmf_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (nrm_start),
        .i_mag   (nrm_in),
        .o_done  (nrm_done),
        .o_mag   (nrm_out)
    );

    pmf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQRT_GO),
        .i_x     (r_acc[SQ_W-1:0]),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    pmf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV_GO),
        .i_num   (div_num),
        .i_den   (r_len),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= 2'd0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_hist0[i] <= '0;
                r_hist1[i] <= '0;
            end
        end else begin
            // While emitting, the emit arm decides what the output register holds next.
            if (r_out_valid && !i_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cur[0]   <= i_point_x;
                        r_cur[1]   <= i_point_y;
                        r_cur[2]   <= i_point_z;
                        r_fin      <= i_final_point;
                        r_frm      <= 2'd0;
                        r_col      <= COL_B;
                        r_last_frm <= i_final_point ? 2'd2 : 2'd0;
                        if (r_seen == 2'd2) begin
                            r_state <= S_LD_D1;
                        end else if (i_final_point) begin
                            r_seen <= 2'd0;
                            for (int i = 0; i < 3; i++) begin
                                r_hist0[i] <= '0;
                                r_hist1[i] <= '0;
                            end
                        end else begin
                            r_seen     <= r_seen + 2'd1;
                            r_hist0    <= r_hist1;
                            r_hist1[0] <= i_point_x;
                            r_hist1[1] <= i_point_y;
                            r_hist1[2] <= i_point_z;
                        end
                    end
                end
                S_LD_D1: begin
                    for (int i = 0; i < 3; i++) begin
                        r_a_sgn[i] <= d1[i] < 0;
                    end
                    r_state <= S_WT_D1;
                end
                S_WT_D1: begin
                    if (nrm_done) begin
                        r_a_mag <= nrm_out;
                        r_u_mag <= nrm_out;
                        r_u_sgn <= r_a_sgn;
                        r_state <= S_LD_D2;
                    end
                end
                S_LD_D2: begin
                    for (int i = 0; i < 3; i++) begin
                        r_c_sgn[i] <= d2[i] < 0;
                    end
                    r_state <= S_WT_D2;
                end
                S_WT_D2: begin
                    if (nrm_done) begin
                        r_c_mag <= nrm_out;
                        r_op    <= OP_AC;
                        r_idx   <= 3'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= opa * opb;
                    r_pneg  <= neg;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= sum;
                    r_idx   <= r_idx + 3'd1;
                    r_state <= S_MUL;
                    unique case (r_op)
                        OP_AC: begin
                            if (r_idx[0]) begin
                                r_cr_mag[kk] <= MAG_W'(sum_mag);
                                r_cr_sgn[kk] <= sum < 0;
                            end
                            if (r_idx == 3'd5) begin
                                // Tangent pass: the scaled first difference is already in place.
                                r_op      <= OP_SQ;
                                r_idx     <= 3'd0;
                                r_phase_n <= 1'b0;
                            end
                        end
                        OP_SQ: begin
                            if (r_idx == 3'd2) begin
                                r_state <= S_SQRT_GO;
                            end
                        end
                        default: begin
                            if (r_idx[0]) begin
                                r_b[kk] <= b_val;
                            end
                            if (r_idx == 3'd5) begin
                                r_state <= S_EMIT;
                            end
                        end
                    endcase
                end
                S_SQRT_GO: begin
                    r_state <= S_SQRT_WT;
                end
                S_SQRT_WT: begin
                    if (sq_done) begin
                        r_len   <= sq_root;
                        r_idx   <= 3'd0;
                        r_state <= S_DIV_GO;
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WT;
                end
                S_DIV_WT: begin
                    if (div_done) begin
                        if (r_phase_n) begin
                            r_n_mag[r_idx[1:0]] <= q_val;
                            r_n_sgn[r_idx[1:0]] <= r_u_sgn[r_idx[1:0]];
                        end else begin
                            r_t_mag[r_idx[1:0]] <= q_val;
                            r_t_sgn[r_idx[1:0]] <= r_u_sgn[r_idx[1:0]];
                        end
                        if (r_idx == 3'd2) begin
                            r_idx <= 3'd0;
                            if (r_phase_n) begin
                                r_op    <= OP_TN;
                                r_state <= S_MUL;
                            end else begin
                                r_state <= S_LD_N;
                            end
                        end else begin
                            r_idx   <= r_idx + 3'd1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_LD_N: begin
                    r_deg <= deg_now;
                    for (int i = 0; i < 3; i++) begin
                        r_u_sgn[i] <= deg_now ? te_sgn[i] : r_cr_sgn[i];
                    end
                    r_state <= S_WT_N;
                end
                S_WT_N: begin
                    if (nrm_done) begin
                        r_u_mag   <= nrm_out;
                        r_phase_n <= 1'b1;
                        r_op      <= OP_SQ;
                        r_idx     <= 3'd0;
                        r_state   <= S_MUL;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= col_x;
                        r_out_y     <= col_y;
                        r_out_z     <= col_z;
                        r_out_idx   <= r_col;
                        r_out_deg   <= r_deg;
                        r_out_eor   <= emit_last;
                        if (emit_last) begin
                            r_state <= S_IDLE;
                            if (r_fin) begin
                                r_seen <= 2'd0;
                                for (int i = 0; i < 3; i++) begin
                                    r_hist0[i] <= '0;
                                    r_hist1[i] <= '0;
                                end
                            end else begin
                                r_hist0 <= r_hist1;
                                r_hist1 <= r_cur;
                            end
                        end else if (r_col == COL_ORG) begin
                            r_col <= COL_B;
                            r_frm <= r_frm + 2'd1;
                        end else begin
                            r_col <= t_col'(r_col + 2'd1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_col_x        = r_out_x;
    assign o_col_y        = r_out_y;
    assign o_col_z        = r_out_z;
    assign o_column_index = r_out_idx;
    assign o_degenerate   = r_out_deg;
    assign o_end_of_run   = r_out_eor;

endmodule

// ===== rtl/pmf_chk.sv =====
// Port-level checks of the moving-frame block, bound to its top level.
module pmf_chk
    import pmf_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic signed [COL_W-1:0] o_col_x,
    input logic signed [COL_W-1:0] o_col_y,
    input logic signed [COL_W-1:0] o_col_z,
    input logic [1:0]              o_column_index,
    input logic                    o_degenerate,
    input logic                    o_end_of_run
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_col_x) && $stable(o_col_y)
        && $stable(o_col_z) && $stable(o_column_index) && $stable(o_degenerate)
        && $stable(o_end_of_run))
        else $error("stalled output beat changed");

    // Within a frame the columns follow back to back in order.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && (o_column_index != COL_ORG)
        |=> o_valid && (o_column_index == $past(o_column_index) + 2'd1))
        else $error("frame columns out of order");

    a_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && (o_column_index != COL_ORG)
        |=> o_degenerate == $past(o_degenerate))
        else $error("degenerate flag changed inside a frame");

    a_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_run |-> o_column_index == COL_ORG)
        else $error("end of run on a column other than the origin");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_column_index != COL_ORG) |-> o_stall)
        else $error("input taken in the middle of a frame");

endmodule

bind polyline_moving_frame pmf_chk u_pmf_chk (.*);

// ===== bench/tb.sv =====
// Self-checking testbench for the polyline moving-frame block.
`timescale 1ns / 1ps

module tb;
    import pmf_pkg::*;

    typedef longint t_vec3 [3];

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [1:0]  idx;
        logic        deg;
        logic        eor;
    } t_column;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic signed [COORD_WIDTH-1:0] i_point_x = '0;
    logic signed [COORD_WIDTH-1:0] i_point_y = '0;
    logic signed [COORD_WIDTH-1:0] i_point_z = '0;
    logic                          i_final_point = 1'b0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic signed [COL_W-1:0]       o_col_x;
    logic signed [COL_W-1:0]       o_col_y;
    logic signed [COL_W-1:0]       o_col_z;
    logic [1:0]                    o_column_index;
    logic                          o_degenerate;
    logic                          o_end_of_run;

    polyline_moving_frame dut (.*);

    // Predictor state: the two previous points and how many, up to two, the run has seen.
    t_vec3   hist_old, hist_new;
    int      run_count;
    t_column frame_cols[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int cols_checked   = 0;
    int frames_seen    = 0;
    int degen_frames   = 0;
    int points_sent    = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic longint unsigned mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint with_sign(bit neg, longint unsigned m);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bits;
        res  = 0;
        bits = 64'd1 << 62;
        while (bits > x) bits >>= 2;
        while (bits != 0) begin
            if (x >= res + bits) begin
                x   = x - (res + bits);
                res = (res >> 1) + bits;
            end else begin
                res >>= 1;
            end
            bits >>= 2;
        end
        return res;
    endfunction

    // Shift the whole vector until its largest magnitude sits in [2^23, 2^24).
    function automatic void block_scale(input t_vec3 v, output t_vec3 o);
        longint unsigned m, mg;
        int sh;
        m  = 0;
        sh = 0;
        for (int i = 0; i < 3; i++) if (mag(v[i]) > m) m = mag(v[i]);
        if (m == 0) begin
            o = '{0, 0, 0};
            return;
        end
        while (m < (64'd1 << 23)) begin m <<= 1; sh++; end
        while (m >= (64'd1 << 24)) begin m >>= 1; sh--; end
        for (int i = 0; i < 3; i++) begin
            mg   = mag(v[i]);
            mg   = sh >= 0 ? (mg << sh) : (mg >> (-sh));
            o[i] = with_sign(v[i] < 0, mg);
        end
    endfunction

    function automatic void unit_of(input t_vec3 v, output t_vec3 o);
        t_vec3 s;
        longint unsigned len2, len, q;
        block_scale(v, s);
        len2 = 0;
        for (int i = 0; i < 3; i++) len2 += mag(s[i]) * mag(s[i]);
        len = int_sqrt(len2);
        for (int i = 0; i < 3; i++) begin
            q    = len == 0 ? 0 : (mag(s[i]) * 65536 + len / 2) / len;
            o[i] = with_sign(s[i] < 0, q);
        end
    endfunction

    function automatic void cross_of(input t_vec3 a, input t_vec3 c, output t_vec3 o);
        o[0] = a[1] * c[2] - a[2] * c[1];
        o[1] = a[2] * c[0] - a[0] * c[2];
        o[2] = a[0] * c[1] - a[1] * c[0];
    endfunction

    function automatic bit frame_of(input t_vec3 p0, input t_vec3 p1, input t_vec3 p2,
                                    output t_vec3 b, output t_vec3 n, output t_vec3 t);
        t_vec3 d1, d2, a, c, cr, e, te;
        bit deg;
        int ix;
        for (int i = 0; i < 3; i++) begin
            d1[i] = p1[i] - p0[i];
            d2[i] = p2[i] - p0[i];
        end
        unit_of(d1, t);
        block_scale(d1, a);
        block_scale(d2, c);
        cross_of(a, c, cr);
        deg = (cr[0] == 0 && cr[1] == 0 && cr[2] == 0);
        if (!deg) begin
            unit_of(cr, n);
        end else begin
            // Fall back on the axis where the tangent is smallest.
            e  = '{0, 0, 0};
            ix = mag(t[0]) < mag(t[1]) ? 0 : 1;
            if (mag(t[2]) < mag(t[ix])) ix = 2;
            e[ix] = 1;
            cross_of(t, e, te);
            unit_of(te, n);
        end
        cross_of(t, n, b);
        for (int i = 0; i < 3; i++) b[i] = with_sign(b[i] < 0, (mag(b[i]) + 32768) >> 16);
        return deg;
    endfunction

    function automatic void push_column(t_vec3 v, t_col idx, bit deg);
        t_column c;
        c.x   = v[0][31:0];
        c.y   = v[1][31:0];
        c.z   = v[2][31:0];
        c.idx = idx;
        c.deg = deg;
        c.eor = 1'b0;
        frame_cols.insert(frame_cols.size(), c);
    endfunction

    // Works out the columns caused by one accepted point and advances the history.
    function automatic void predict_point(t_vec3 cur, bit fin);
        t_vec3 b, n, t, org;
        bit deg;
        if (run_count >= 2) begin
            deg = frame_of(hist_old, hist_new, cur, b, n, t);
            for (int f = 0; f < (fin ? 3 : 1); f++) begin
                org = f == 0 ? hist_old : (f == 1 ? hist_new : cur);
                push_column(b, COL_B, deg);
                push_column(n, COL_N, deg);
                push_column(t, COL_T, deg);
                push_column(org, COL_ORG, deg);
                frames_seen++;
                if (deg) degen_frames++;
            end
            frame_cols[$].eor = 1'b1;
        end
        if (fin) begin
            hist_old  = '{0, 0, 0};
            hist_new  = '{0, 0, 0};
            run_count = 0;
        end else begin
            hist_old = hist_new;
            hist_new = cur;
            if (run_count < 2) run_count++;
        end
    endfunction

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit fin);
        t_vec3 cur;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_point_x     <= x;
        i_point_y     <= y;
        i_point_z     <= z;
        i_final_point <= fin;
        do @(posedge i_clk); while (o_stall);
        cur = '{longint'($signed(x)), longint'($signed(y)), longint'($signed(z))};
        predict_point(cur, fin);
        points_sent++;
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_column e;
        if (i_rst_n && o_valid && !i_stall) begin
            cols_checked++;
            if (frame_cols.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected column: x=%h y=%h z=%h idx=%0d",
                             o_col_x, o_col_y, o_col_z, o_column_index);
            end else begin
                e = frame_cols.pop_front();
                if (o_col_x !== e.x || o_col_y !== e.y || o_col_z !== e.z ||
                    o_column_index !== e.idx || o_degenerate !== e.deg ||
                    o_end_of_run !== e.eor) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %h i%0d d%0b e%0b, got %h %h %h %0d %0b %0b",
                                 e.x, e.y, e.z, e.idx, e.deg, e.eor, o_col_x, o_col_y,
                                 o_col_z, o_column_index, o_degenerate, o_end_of_run);
                end
            end
        end
    end

    task automatic test_plain_frames;
        send_point(32'd0, 32'd0, 32'd0, 1'b0);
        send_point(32'h0001_0000, 32'd0, 32'd0, 1'b0);
        send_point(32'd0, 32'h0001_0000, 32'd0, 1'b0);
        send_point(32'h0003_8000, 32'hFFFE_0000, 32'h0000_4000, 1'b1);
    endtask

    task automatic test_extremes;
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    endtask

    task automatic test_degenerate;
        // Collinear window: the cross product is exactly zero.
        send_point(32'd0, 32'd0, 32'd0, 1'b0);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
        send_point(32'h0002_0000, 32'h0004_0000, 32'h0006_0000, 1'b1);
        // Repeated point leaves the tangent at zero.
        send_point(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 1'b0);
        send_point(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 1'b0);
        send_point(32'h0009_0000, 32'h0001_0000, 32'h0000_0000, 1'b1);
        // Tangent with two equal small components exercises the axis tie.
        send_point(32'd0, 32'd0, 32'd0, 1'b0);
        send_point(32'd0, 32'd0, 32'h0001_0000, 1'b0);
        send_point(32'd0, 32'd0, 32'h0002_0000, 1'b1);
    endtask

    task automatic test_short_runs;
        send_point(32'h1234_5678, 32'h0, 32'h0, 1'b1);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0, 1'b0);
        send_point(32'h0, 32'h0, 32'h0003_0000, 1'b1);
    endtask

    function automatic logic [31:0] rand_coord(int kind);
        case (kind)
            0:       return $urandom();
            1:       return $signed($urandom_range(2_000_000)) - 1_000_000;
            default: return $signed($urandom_range(400)) - 200;
        endcase
    endfunction

    task automatic test_random_runs(int n_items);
        logic [31:0] p0[3], p1[3], q[3];
        int sent, len, kind, k;
        sent = 0;
        while (sent < n_items) begin
            len  = $urandom_range(9) < 2 ? $urandom_range(1, 2) : $urandom_range(3, 8);
            kind = $urandom_range(2);
            for (int i = 0; i < len; i++) begin
                for (int a = 0; a < 3; a++) q[a] = rand_coord(kind);
                if (i >= 2 && $urandom_range(9) == 0) begin
                    // Collinear continuation of the last two points.
                    k = $urandom_range(1, 3);
                    for (int a = 0; a < 3; a++) q[a] = p1[a] + k * (p1[a] - p0[a]);
                end else if (i >= 1 && $urandom_range(14) == 0) begin
                    q = p1;
                end
                send_point(q[0], q[1], q[2], i == len - 1 && $urandom_range(9) != 0);
                p0 = p1;
                p1 = q;
                sent++;
            end
        end
        // Close any run left open so its tail frames are checked.
        send_point($urandom(), $urandom(), $urandom(), 1'b1);
    endtask

    initial begin
        hist_old  = '{0, 0, 0};
        hist_new  = '{0, 0, 0};
        run_count = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_frames();
        test_extremes();
        send_idle_pct  = 55;
        recv_stall_pct = 55;
        test_degenerate();
        test_short_runs();

        send_idle_pct = 0;  recv_stall_pct = 0;  test_random_runs(32);
        send_idle_pct = 55; recv_stall_pct = 0;  test_random_runs(32);
        send_idle_pct = 0;  recv_stall_pct = 55; test_random_runs(32);
        send_idle_pct = 29; recv_stall_pct = 29; test_random_runs(32);

        i_valid <= 1'b0;
        while (frame_cols.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        $display("tb: %0d points sent, %0d frames (%0d degenerate), %0d columns checked",
                 points_sent, frames_seen, degen_frames, cols_checked);
        $display("tb: %0d mismatches under four idle and stall mixes", mismatches);
        if (mismatches == 0 && frame_cols.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
